/* design/vwcg_pkg.sv */
// Shared types and constants for the velocity window candidate grid.
package vwcg_pkg;

  // Divider operand widths: dividends are 16-bit magnitudes, divisors are sample counts minus one.
  localparam int DIV_W = 16;
  localparam int REM_W = 3;
  localparam int CNT_W = 3;

  // Configuration register indexes.
  localparam logic [2:0] REG_MIN_LINEAR    = 3'd0;
  localparam logic [2:0] REG_VEL_WINDOW    = 3'd1;
  localparam logic [2:0] REG_MAX_ANGULAR   = 3'd2;
  localparam logic [2:0] REG_LINEAR_COUNT  = 3'd3;
  localparam logic [2:0] REG_ANGULAR_COUNT = 3'd4;

  // Row source select.
  localparam logic [1:0] ROW_ZERO   = 2'd0;
  localparam logic [1:0] ROW_SAMPLE = 2'd1;
  localparam logic [1:0] ROW_REV    = 2'd2;
  localparam logic [1:0] ROW_HALF   = 2'd3;

  typedef struct packed {
    logic signed [15:0] current_velocity;
    logic signed [15:0] speed_cap;
  } request_t;

  typedef struct packed {
    logic signed [15:0] linear_velocity;
    logic signed [15:0] angular_velocity;
    logic               last_candidate;
  } result_t;

  typedef struct packed {
    logic signed [15:0] min_linear_velocity;
    logic [14:0]        velocity_window;
    logic [14:0]        max_angular_velocity;
    logic [2:0]         linear_sample_count;
    logic [2:0]         angular_sample_count;
  } config_t;

  typedef struct packed {
    logic       load;
    logic       fix;
    logic       div_start;
    logic       emit;
    logic       last;
    logic       col_adv;
    logic       lin_step;
    logic [1:0] row_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic col_last;
    logic samp_kept;
    logic samp_last;
    logic rev_active;
    logic hi_pos;
  } dp_stat_t;

endpackage

/* design/vwcg_div.sv */
// Restoring divider: 16-bit unsigned dividend by a small divisor, one quotient bit per cycle.
module vwcg_div
  import vwcg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [REM_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot,
  output logic [REM_W-1:0] rem
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [STEP_W-1:0] steps;
  logic [REM_W:0]    trial;
  logic              fits;

  assign trial = {rem, quot[DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign done  = steps == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(DIV_W);
    end else if (!done) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (!done) begin
      quot <= {quot[DIV_W-2:0], fits};
      rem  <= fits ? REM_W'(trial - {1'b0, divisor}) : trial[REM_W-1:0];
    end
  end

endmodule

/* design/vwcg_dp.sv */
// Datapath: window bounds, two dividers, row and column accumulators, result register.
module vwcg_dp
  import vwcg_pkg::*;
#(
  parameter int MAX_LINEAR_SAMPLES  = 5,
  parameter int MAX_ANGULAR_SAMPLES = 7
) (
  input  logic     clk,
  input  logic     rst,
  input  request_t request,
  input  config_t  cfg,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output logic     valid,
  output result_t  result
);

  logic signed [15:0] v_rev, hi_raw, lo, hi;
  logic [14:0]        wmax;
  logic [CNT_W-1:0]   nl, na;
  logic [CNT_W-1:0]   nl_clamp, na_clamp;

  logic signed [16:0] cur_ext, lo_diff, hi_sum, vmin_ext, cap_ext, win_span;
  logic signed [15:0] fixed_lo;

  logic [DIV_W-1:0]   lin_qd, ang_qd;
  logic [REM_W-1:0]   lin_rd, ang_rd;
  logic               lin_done, ang_done;

  logic [DIV_W-1:0]   lin_q, ang_q;
  logic [REM_W-1:0]   lin_r, ang_r;
  logic [CNT_W-1:0]   lin_idx, col_idx;
  logic [REM_W:0]     lin_rsum, ang_rsum;
  logic               lin_carry, ang_carry;

  logic signed [17:0] samp;
  logic signed [16:0] col_raw;
  logic signed [15:0] row_val, col_val;

  // Sample counts held to their legal ranges.
  always_comb begin
    nl_clamp = cfg.linear_sample_count;
    if (nl_clamp < 3'd2) nl_clamp = 3'd2;
    if (nl_clamp > CNT_W'(MAX_LINEAR_SAMPLES)) nl_clamp = CNT_W'(MAX_LINEAR_SAMPLES);
    na_clamp = cfg.angular_sample_count;
    if (na_clamp < 3'd3) na_clamp = 3'd3;
    if (na_clamp > CNT_W'(MAX_ANGULAR_SAMPLES)) na_clamp = CNT_W'(MAX_ANGULAR_SAMPLES);
  end

  assign cur_ext  = {request.current_velocity[15], request.current_velocity};
  assign vmin_ext = {cfg.min_linear_velocity[15], cfg.min_linear_velocity};
  assign cap_ext  = {request.speed_cap[15], request.speed_cap};
  assign lo_diff  = cur_ext - {2'b00, cfg.velocity_window};
  assign hi_sum   = cur_ext + {2'b00, cfg.velocity_window};
  assign fixed_lo = (cfg.min_linear_velocity > hi_raw) ? cfg.min_linear_velocity : hi_raw;
  assign win_span = {hi[15], hi} - {lo[15], lo};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_rev  <= (vmin_ext > lo_diff) ? cfg.min_linear_velocity : lo_diff[15:0];
      hi_raw <= (hi_sum > cap_ext) ? request.speed_cap : hi_sum[15:0];
      wmax   <= cfg.max_angular_velocity;
      nl     <= nl_clamp;
      na     <= na_clamp;
    end
    if (cmd.fix) begin
      if (hi_raw < v_rev) begin
        lo <= fixed_lo;
        hi <= fixed_lo;
      end else begin
        lo <= v_rev;
        hi <= hi_raw;
      end
    end
  end

  vwcg_div u_lin_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (win_span[DIV_W-1:0]),
    .divisor  (nl - 1'b1),
    .done     (lin_done),
    .quot     (lin_qd),
    .rem      (lin_rd)
  );

  vwcg_div u_ang_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({wmax, 1'b0}),
    .divisor  (na - 1'b1),
    .done     (ang_done),
    .quot     (ang_qd),
    .rem      (ang_rd)
  );

  // Sample i of a span D over n steps is Q*i + floor(R*i/n); the remainder
  // accumulates and carries into the quotient once it reaches n.
  assign lin_rsum  = {1'b0, lin_r} + {1'b0, lin_rd};
  assign lin_carry = lin_rsum >= {1'b0, nl - 1'b1};
  assign ang_rsum  = {1'b0, ang_r} + {1'b0, ang_rd};
  assign ang_carry = ang_rsum >= {1'b0, na - 1'b1};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      lin_q   <= '0;
      lin_r   <= '0;
      lin_idx <= '0;
    end else if (cmd.lin_step) begin
      lin_q   <= lin_q + lin_qd + DIV_W'(lin_carry);
      lin_r   <= lin_carry ? REM_W'(lin_rsum - {1'b0, nl - 1'b1}) : lin_rsum[REM_W-1:0];
      lin_idx <= lin_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start || (cmd.col_adv && stat.col_last)) begin
      ang_q   <= '0;
      ang_r   <= '0;
      col_idx <= '0;
    end else if (cmd.col_adv) begin
      ang_q   <= ang_q + ang_qd + DIV_W'(ang_carry);
      ang_r   <= ang_carry ? REM_W'(ang_rsum - {1'b0, na - 1'b1}) : ang_rsum[REM_W-1:0];
      col_idx <= col_idx + 1'b1;
    end
  end

  assign samp    = {{2{lo[15]}}, lo} + {2'b00, lin_q};
  assign col_raw = {1'b0, ang_q} - {2'b00, wmax};
  assign col_val = (col_idx == na) ? 16'sd0 : col_raw[15:0];

  always_comb begin
    case (cmd.row_sel)
      ROW_ZERO:   row_val = 16'sd0;
      ROW_SAMPLE: row_val = samp[15:0];
      ROW_REV:    row_val = v_rev;
      ROW_HALF:   row_val = v_rev >>> 1;
      default:    row_val = 16'sd0;
    endcase
  end

  assign stat.div_done   = lin_done && ang_done;
  assign stat.col_last   = (wmax != '0) ? (col_idx == na) : (col_idx == na - 1'b1);
  assign stat.samp_kept  = samp > 18'sd4;
  assign stat.samp_last  = lin_idx == nl - 1'b1;
  assign stat.rev_active = v_rev < -16'sd4;
  assign stat.hi_pos     = hi > 16'sd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.linear_velocity  <= row_val;
      result.angular_velocity <= col_val;
      result.last_candidate   <= cmd.last;
    end
  end

endmodule

/* design/vwcg_ctrl.sv */
// Controller: sequences setup, division and the row-by-row walk of the grid.
module vwcg_ctrl
  import vwcg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIX  = 3'd1;
  localparam logic [2:0] S_DGO  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ZERO = 3'd4;
  localparam logic [2:0] S_SAMP = 3'd5;
  localparam logic [2:0] S_REV  = 3'd6;
  localparam logic [2:0] S_HALF = 3'd7;

  logic [2:0] state, state_next;

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.row_sel = ROW_ZERO;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_DGO;
      end
      S_DGO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_ZERO;
      end
      S_ZERO: begin
        cmd.emit    = 1'b1;
        cmd.col_adv = 1'b1;
        cmd.last    = stat.col_last && !stat.rev_active && !stat.hi_pos;
        if (stat.col_last) begin
          if (stat.hi_pos) begin
            state_next = S_SAMP;
          end else if (stat.rev_active) begin
            state_next = S_REV;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_SAMP: begin
        cmd.row_sel = ROW_SAMPLE;
        if (stat.samp_kept) begin
          cmd.emit    = 1'b1;
          cmd.col_adv = 1'b1;
          cmd.last    = stat.col_last && stat.samp_last && !stat.rev_active;
          if (stat.col_last) begin
            cmd.lin_step = 1'b1;
            if (stat.samp_last) state_next = stat.rev_active ? S_REV : S_IDLE;
          end
        end else begin
          // Samples rise toward the upper bound, so a dropped one is never the last.
          cmd.lin_step = 1'b1;
        end
      end
      S_REV: begin
        cmd.row_sel = ROW_REV;
        cmd.emit    = 1'b1;
        cmd.col_adv = 1'b1;
        if (stat.col_last) state_next = S_HALF;
      end
      S_HALF: begin
        cmd.row_sel = ROW_HALF;
        cmd.emit    = 1'b1;
        cmd.col_adv = 1'b1;
        cmd.last    = stat.col_last;
        if (stat.col_last) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/velocity_window_candidate_grid.sv */
// Top level of the velocity window candidate grid: configuration registers and block wiring.
//
// Usage: present an item on request (current_velocity, speed_cap) and raise start.
// The item is taken at a rising edge where start is high and busy is low; busy then
// stays high until the last pair of that item's grid has been registered.
// Results appear on result one pair per cycle, with none for a dropped linear sample, each
// marked by valid for exactly one cycle; the final pair of a grid carries last_candidate.
// There is no back-pressure, so the receiver must take every pair in the cycle it appears.
// The grid is a zero row, the kept linear samples across the reachable window, and
// optionally a reverse row and its half, each crossed with the angular columns.
// Sequence: the accepting edge loads the request and configuration; the controller then
// fixes the window bounds, starts the two restoring dividers and waits until both have
// their 16-bit quotients; the zero-row state then registers the first pair. A new item
// is accepted in the cycle that the final pair of the previous one is shown.
// Reset (rst, synchronous, active high) returns the controller to idle, clears valid
// and loads the configuration registers with their defaults. Configuration is written
// through cfg_we, cfg_index and cfg_data; unknown indexes are ignored. The user must see
// that it is written only while the block is idle; the block itself does not enforce this.
module velocity_window_candidate_grid
  import vwcg_pkg::*;
#(
  parameter int MAX_LINEAR_SAMPLES  = 5,
  parameter int MAX_ANGULAR_SAMPLES = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  request_t    request,
  output logic        valid,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  config_t  cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration registers; each write takes effect at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_linear_velocity  <= 16'sd0;
      cfg.velocity_window      <= 15'd1024;
      cfg.max_angular_velocity <= 15'd4096;
      cfg.linear_sample_count  <= 3'd5;
      cfg.angular_sample_count <= 3'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_LINEAR:    cfg.min_linear_velocity  <= cfg_data;
        REG_VEL_WINDOW:    cfg.velocity_window      <= cfg_data[14:0];
        REG_MAX_ANGULAR:   cfg.max_angular_velocity <= cfg_data[14:0];
        REG_LINEAR_COUNT:  cfg.linear_sample_count  <= cfg_data[2:0];
        REG_ANGULAR_COUNT: cfg.angular_sample_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // The controller walks setup, division and the rows; the datapath does the arithmetic.
  vwcg_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  vwcg_dp #(
    .MAX_LINEAR_SAMPLES  (MAX_LINEAR_SAMPLES),
    .MAX_ANGULAR_SAMPLES (MAX_ANGULAR_SAMPLES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cfg     (cfg),
    .cmd     (cmd),
    .stat    (stat),
    .valid   (valid),
    .result  (result)
  );

  // An accepted item always makes the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("block not busy after accepting an item");

  // The block only goes idle as the final pair of a grid is shown.
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> valid && result.last_candidate)
    else $error("went idle without delivering the final pair");

  // A pair shown while idle must be the final pair of its grid.
  assert property (@(posedge clk) disable iff (rst) valid && !busy |-> result.last_candidate)
    else $error("pair shown while idle is not the final one");

endmodule
